### hw/rtl/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, constants and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

    // Magnitude and digit row geometry
    localparam int MAG_W      = 64;
    localparam int HALF_W     = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 19;   // 2^63 has 19 decimal digits
    localparam int CNT_W      = 7;    // holds MAG_W
    localparam int REM_W      = 5;    // holds NUM_DIGITS
    localparam int CHAR_W     = 8;

    // Command codes
    localparam logic [1:0] CMD_DEC32 = 2'd0;
    localparam logic [1:0] CMD_DEC64 = 2'd1;
    localparam logic [1:0] CMD_HEX32 = 2'd2;

    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_LOW_A = 8'h61;

    localparam logic [DIGIT_W-1:0] DEC_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DEC_ADJ     = 4'd3;
    localparam logic [DIGIT_W-1:0] DEC_BASE    = 4'd10;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ALIGN,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Control fanned out to every cell of the digit row
    typedef struct packed {
        logic clear;        // zero the digit
        logic shift_bit;    // double-dabble step: adjust, then shift in one bit
        logic shift_digit;  // move every digit one cell toward the top
        logic decimal;      // apply the add-3 adjust (off in hex mode)
    } ita_ctl_t;

    // Digit value to its lowercase ASCII glyph
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_BASE) begin
            digit_glyph = ASCII_ZERO + wide;
        end else begin
            digit_glyph = ASCII_LOW_A + wide - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_BASE};
        end
    endfunction

endpackage

### hw/rtl/ita_cell.sv
// ----------------------------------------------------------------------------
// ita_cell
// One digit of the conversion row. Holds a 4-bit digit, takes one bit from
// its lower neighbor on a double-dabble step and passes its carry up.
// ----------------------------------------------------------------------------
module ita_cell (
    input  logic                       clk,
    input  ita_pkg::ita_ctl_t          ctl,
    input  logic                       bit_in,
    input  logic [ita_pkg::DIGIT_W-1:0] digit_in,
    output logic                       bit_out,
    output logic [ita_pkg::DIGIT_W-1:0] digit
);
    import ita_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // Add-3 correction ahead of the shift (decimal only)
    always_comb
    begin
        if (ctl.decimal && (digit_reg >= DEC_ADJ_MIN)) begin
            adj = digit_reg + DEC_ADJ;
        end else begin
            adj = digit_reg;
        end
    end

    assign bit_out = adj[DIGIT_W-1];
    assign digit   = digit_reg;

    // Next digit
    always_comb
    begin
        if (ctl.clear) begin
            digit_next = '0;
        end else if (ctl.shift_bit) begin
            digit_next = {adj[DIGIT_W-2:0], bit_in};
        end else if (ctl.shift_digit) begin
            digit_next = digit_in;
        end else begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

### hw/rtl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer as ASCII characters, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes a command and a 64-bit value:
//   signed 32-bit decimal, signed 64-bit decimal or unsigned 32-bit hex.
//   Output channel (out_valid/out_ready) returns the characters of a request,
//   with last set on the final character. Command 3 is taken and dropped.
// Timing:
//   A request is converted by a row of 19 digit cells, one magnitude bit per
//   cycle: all 64 bits for 64-bit decimal, 32 bits for the other modes.
//   Leading zero digits are then stripped one per cycle, and characters
//   leave one per cycle while out_ready stays high (sign first); each of
//   the 19 digits is either stripped or emitted. in_ready rises in the same
//   cycle that the final character first sits in the output register.
// Reset:
//   rst_n clears the sequencer and the output valid; no character is lost
//   or repeated when the receiver stalls: the sequencer waits on out_ready.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  command,
    input  logic signed [ita_pkg::MAG_W-1:0] value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ita_pkg::CHAR_W-1:0]  character,
    output logic                        last
);
    import ita_pkg::*;

    state_t               state_reg, state_next;
    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic                 dec_reg, dec_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    character_reg, character_next;
    logic                 last_reg, last_next;

    ita_ctl_t             ctl;
    logic                 in_acc;
    logic                 out_free;
    logic                 load_out;
    logic [DIGIT_W-1:0]   digits [NUM_DIGITS];
    logic                 carry  [NUM_DIGITS];
    logic [DIGIT_W-1:0]   top_digit;
    logic [HALF_W-1:0]    lo;
    logic [HALF_W-1:0]    lo_mag;
    logic [MAG_W-1:0]     full_mag;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign top_digit = digits[NUM_DIGITS-1];

    // Magnitude of the incoming value
    assign lo       = value[HALF_W-1:0];
    assign lo_mag   = lo[HALF_W-1] ? (~lo + 1'b1) : lo;
    assign full_mag = value[MAG_W-1] ? (~value + 1'b1) : value;

    // Digit row
    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
            logic               b_in;
            logic [DIGIT_W-1:0] d_in;
            if (gi == 0) begin : g_first
                assign b_in = mag_reg[MAG_W-1];
                assign d_in = '0;
            end else begin : g_rest
                assign b_in = carry[gi-1];
                assign d_in = digits[gi-1];
            end
            ita_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .bit_in   (b_in),
                .digit_in (d_in),
                .bit_out  (carry[gi]),
                .digit    (digits[gi])
            );
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && (command == CMD_DEC32 || command == CMD_DEC64 ||
                               command == CMD_HEX32)) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (!((top_digit == '0) && (rem_reg > REM_W'(1)))) begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && (rem_reg == REM_W'(1))) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output control
    always_comb
    begin
        mag_next       = mag_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        dec_next       = dec_reg;
        character_next = character_reg;
        last_next      = last_reg;
        load_out       = 1'b0;
        ctl            = '{clear: 1'b0, shift_bit: 1'b0, shift_digit: 1'b0,
                           decimal: dec_reg};
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    ctl.clear = 1'b1;
                    rem_next  = REM_W'(NUM_DIGITS);
                    dec_next  = (command != CMD_HEX32);
                    if (command == CMD_DEC64) begin
                        mag_next = full_mag;
                        neg_next = value[MAG_W-1];
                        cnt_next = CNT_W'(MAG_W);
                    end else begin
                        mag_next = (command == CMD_DEC32) ? {lo_mag, {HALF_W{1'b0}}}
                                                          : {lo, {HALF_W{1'b0}}};
                        neg_next = (command == CMD_DEC32) && lo[HALF_W-1];
                        cnt_next = CNT_W'(HALF_W);
                    end
                end
            end
            ST_CONV: begin
                ctl.shift_bit = 1'b1;
                mag_next      = {mag_reg[MAG_W-2:0], 1'b0};
                cnt_next      = cnt_reg - 1'b1;
            end
            ST_ALIGN: begin
                if ((top_digit == '0) && (rem_reg > REM_W'(1))) begin
                    ctl.shift_digit = 1'b1;
                    rem_next        = rem_reg - 1'b1;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    load_out       = 1'b1;
                    character_next = ASCII_MINUS;
                    last_next      = 1'b0;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out        = 1'b1;
                    character_next  = digit_glyph(top_digit);
                    last_next       = (rem_reg == REM_W'(1));
                    ctl.shift_digit = 1'b1;
                    rem_next        = rem_reg - 1'b1;
                end
            end
            default: ;
        endcase

        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        dec_reg       <= dec_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    // Bit counter never runs out while converting
    a_conv_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (cnt_reg != '0))
        else $error("conversion counter reached zero");

    // Emission always has a digit left within the row
    a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rem_reg != '0 && rem_reg <= REM_W'(NUM_DIGITS)))
        else $error("digit count out of range");

    // Hex conversion leaves at most eight significant digits
    a_hex_width: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !dec_reg) |-> (rem_reg <= REM_W'(8)))
        else $error("hex value wider than eight digits");

    // The sign is always followed by the digits of the same request
    a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |=> (state_reg == ST_SIGN || state_reg == ST_EMIT))
        else $error("sign not followed by digits");
`endif

endmodule
